// ===== rtl/core/idqe_pkg.sv =====
// idqe_pkg: request codes, result status codes and sequencer states
// for the indexed deque engine; no dependencies
`default_nettype none

package idqe_pkg;

  typedef enum logic [3:0] {
    REQ_PUSH_TAIL = 4'd0,
    REQ_PUSH_HEAD = 4'd1,
    REQ_POP_TAIL  = 4'd2,
    REQ_POP_HEAD  = 4'd3,
    REQ_READ      = 4'd4,
    REQ_INSERT    = 4'd5,
    REQ_REMOVE    = 4'd6,
    REQ_SWAP      = 4'd7,
    REQ_CLEAR     = 4'd8
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_SWAP1 = 7'b0010000,
    S_SWAP2 = 7'b0100000,
    S_SWAP3 = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/idqe_store.sv =====
// idqe_store: word store of the deque, one write and one read port,
// read data registered; no dependencies
`default_nettype none

module idqe_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_deque_engine.sv =====
// indexed_deque_engine: bounded double-ended queue with indexed access, uses idqe_pkg, idqe_store
// push, clear and errors finish from idle; pop and read pass through S_FETCH; swap through S_SWAP1 to S_SWAP3
// insert and remove shift one entry per cycle through the store in S_SHIFT, insert ending in S_PUT
// one request at a time; the next word is taken in the cycle the result is strobed
// the result word is strobed by done_o for one cycle, no stall possible
// reset clears count and front slot at once; store contents stay undefined
`default_nettype none

module indexed_deque_engine #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   req_type_i,
  input  logic [WIDTH-1:0]             data_in_i,
  input  logic [$clog2(DEPTH)-1:0]     position_i,
  input  logic [$clog2(DEPTH)-1:0]     second_position_i,
  output logic                         done_o,
  output logic [WIDTH-1:0]             data_out_o,
  output idqe_pkg::status_e            status_o,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy_o
);

  import idqe_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic              done_q, done_d;
  req_e              op_q, op_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  pos2_q, pos2_d;
  logic [WIDTH-1:0]  din_q, din_d;
  logic [WIDTH-1:0]  tmp_q, tmp_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic [IDX_W-1:0]  widx_q, widx_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              pend_q, pend_d;
  logic              up_q, up_d;
  logic [WIDTH-1:0]  res_data_q, res_data_d;
  status_e           res_stat_q, res_stat_d;
  logic [CNT_W-1:0]  res_occ_q, res_occ_d;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [WIDTH-1:0]  mem_wdata, mem_rdata;

  logic              full, empty;
  logic [CNT_W-1:0]  pos_c, pos2_c, ins_c, cnt_m1_c;
  logic [IDX_W-1:0]  cnt_idx, front_m1, front_p1;

  idqe_store #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign pos_c    = CNT_W'(position_i);
  assign pos2_c   = CNT_W'(second_position_i);
  assign ins_c    = (pos_c > count_q) ? count_q : pos_c;
  assign cnt_m1_c = count_q - CNT_W'(1);
  assign cnt_idx  = count_q[IDX_W-1:0];
  assign front_m1 = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
  assign front_p1 = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    front_d    = front_q;
    done_d     = 1'b0;
    op_d       = op_q;
    pos_d      = pos_q;
    pos2_d     = pos2_q;
    din_d      = din_q;
    tmp_d      = tmp_q;
    ridx_d     = ridx_q;
    widx_d     = widx_q;
    left_d     = left_q;
    pend_d     = pend_q;
    up_d       = up_q;
    res_data_d = res_data_q;
    res_stat_d = res_stat_q;
    res_occ_d  = res_occ_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = din_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = req_e'(req_type_i);
          pos_d      = position_i;
          pos2_d     = second_position_i;
          din_d      = data_in_i;
          res_data_d = '0;
          res_stat_d = STAT_OK;
          done_d     = 1'b1;
          unique case (req_e'(req_type_i))
            REQ_PUSH_TAIL: begin
              if (full) begin
                res_stat_d = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(front_q, cnt_idx);
                mem_wdata = data_in_i;
                count_d   = count_q + CNT_W'(1);
              end
            end
            REQ_PUSH_HEAD: begin
              if (full) begin
                res_stat_d = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_m1;
                mem_wdata = data_in_i;
                front_d   = front_m1;
                count_d   = count_q + CNT_W'(1);
              end
            end
            REQ_POP_TAIL: begin
              if (empty) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(front_q, cnt_m1_c[IDX_W-1:0]);
                count_d   = cnt_m1_c;
                done_d    = 1'b0;
                state_d   = S_FETCH;
              end
            end
            REQ_POP_HEAD: begin
              if (empty) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q;
                front_d   = front_p1;
                count_d   = cnt_m1_c;
                done_d    = 1'b0;
                state_d   = S_FETCH;
              end
            end
            REQ_READ: begin
              if (pos_c >= count_q) begin
                res_stat_d = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(front_q, position_i);
                done_d    = 1'b0;
                state_d   = S_FETCH;
              end
            end
            REQ_INSERT: begin
              if (full) begin
                res_stat_d = STAT_FULL;
              end else begin
                pos_d   = ins_c[IDX_W-1:0];
                ridx_d  = cnt_m1_c[IDX_W-1:0];
                widx_d  = cnt_idx;
                left_d  = count_q - ins_c;
                pend_d  = 1'b0;
                up_d    = 1'b0;
                count_d = count_q + CNT_W'(1);
                done_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            REQ_REMOVE: begin
              if (empty) begin
                res_stat_d = STAT_EMPTY;
              end else if (pos_c >= count_q) begin
                res_stat_d = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(front_q, position_i);
                ridx_d    = position_i + IDX_W'(1);
                widx_d    = position_i;
                left_d    = cnt_m1_c - pos_c;
                pend_d    = 1'b0;
                up_d      = 1'b1;
                count_d   = cnt_m1_c;
                done_d    = 1'b0;
                state_d   = S_FETCH;
              end
            end
            REQ_SWAP: begin
              if ((pos_c >= count_q) || (pos2_c >= count_q)) begin
                res_stat_d = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_of(front_q, position_i);
                done_d    = 1'b0;
                state_d   = S_SWAP1;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
              front_d = '0;
            end
            default: begin
            end
          endcase
          res_occ_d = count_d;
        end
      end
      S_FETCH: begin
        res_data_d = mem_rdata;
        if (op_q == REQ_REMOVE) begin
          state_d = S_SHIFT;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(front_q, widx_q);
          mem_wdata = mem_rdata;
          widx_d    = up_q ? widx_q + IDX_W'(1) : widx_q - IDX_W'(1);
        end
        if (left_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(front_q, ridx_q);
          ridx_d    = up_q ? ridx_q + IDX_W'(1) : ridx_q - IDX_W'(1);
          left_d    = left_q - CNT_W'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (op_q == REQ_INSERT) begin
            state_d = S_PUT;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(front_q, pos_q);
        mem_wdata = din_q;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_SWAP1: begin
        tmp_d     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = slot_of(front_q, pos2_q);
        state_d   = S_SWAP2;
      end
      S_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(front_q, pos_q);
        mem_wdata = mem_rdata;
        state_d   = S_SWAP3;
      end
      S_SWAP3: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(front_q, pos2_q);
        mem_wdata = tmp_q;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      front_q <= '0;
      done_q  <= 1'b0;
      left_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      front_q <= front_d;
      done_q  <= done_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_q      <= pos_d;
    pos2_q     <= pos2_d;
    din_q      <= din_d;
    tmp_q      <= tmp_d;
    ridx_q     <= ridx_d;
    widx_q     <= widx_d;
    up_q       <= up_d;
    res_data_q <= res_data_d;
    res_stat_q <= res_stat_d;
    res_occ_q  <= res_occ_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign data_out_o  = res_data_q;
  assign status_o    = res_stat_q;
  assign occupancy_o = res_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> (occupancy_o == CNT_W'(DEPTH)))
    else $error("full status with free entries");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_EMPTY)) |-> (occupancy_o == '0))
    else $error("empty status with live entries");

  a_shift_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHIFT) && (left_q != '0)) |=>
      (left_q == $past(left_q) - CNT_W'(1)))
    else $error("shift counter skipped a step");

  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !$past(busy) && $past(start)) |-> !done_o)
    else $error("result word strobed while a long request starts");

endmodule

`default_nettype wire
